[design/mts_pkg.sv]
package mts_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int DATA_WIDTH  = 32;

    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic load;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic needs_load;
        logic out_free;
    } t_dp_sts;

endpackage

[design/mts_req_if.sv]
interface mts_req_if #(
    parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   kind;
    logic signed [DATA_WIDTH-1:0] value;

    modport source (output valid, kind, value, input ready);
    modport sink   (input valid, kind, value, output ready);
endinterface

[design/mts_rsp_if.sv]
interface mts_rsp_if #(
    parameter int DATA_WIDTH  = mts_pkg::DATA_WIDTH,
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH
);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] top_value;
    logic signed [DATA_WIDTH-1:0] min_value;
    logic                         is_empty;
    logic [CW-1:0]                depth;
    logic [1:0]                   status;

    modport source (output valid, top_value, min_value, is_empty, depth, status,
                    input ready);
    modport sink   (input valid, top_value, min_value, is_empty, depth, status,
                    output ready);
endinterface

[design/min_tracking_stack.sv]
// a request is taken only in the idle state; a pop that removes an entry then passes
// the load state, which refreshes the cached tops from the registered read of the
// stack memories, and the done state emits the result once the output is free
// a result waiting in the output register does not block the next request
// reset: synchronous active low, empties both stacks; memory contents are kept
module min_tracking_stack #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH,
    parameter int DATA_WIDTH  = mts_pkg::DATA_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mts_req_if.sink   i_req,
    mts_rsp_if.source o_rsp
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    mts_pkg::t_dp_cmd cmd;
    mts_pkg::t_dp_sts sts;

    mts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mts_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH),
        .CW          (CW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_kind      (i_req.kind),
        .i_value     (i_req.value),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_valid     (o_rsp.valid),
        .i_ready     (o_rsp.ready),
        .o_top_value (o_rsp.top_value),
        .o_min_value (o_rsp.min_value),
        .o_is_empty  (o_rsp.is_empty),
        .o_depth     (o_rsp.depth),
        .o_status    (o_rsp.status)
    );

endmodule

[design/mts_ctrl.sv]
module mts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  mts_pkg::t_dp_sts i_sts,
    output mts_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ready    = 1'b0;
        o_cmd.exec = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_sts.needs_load ? S_LOAD : S_DONE;
                end
            end
            S_LOAD: begin
                // refresh the cached tops from the memory read issued on the pop
                o_cmd.load = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[design/mts_dp.sv]
module mts_dp #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH,
    parameter int DATA_WIDTH  = mts_pkg::DATA_WIDTH,
    parameter int CW          = $clog2(STACK_DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [1:0]                   i_kind,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    input  mts_pkg::t_dp_cmd             i_cmd,
    output mts_pkg::t_dp_sts             o_sts,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_top_value,
    output logic signed [DATA_WIDTH-1:0] o_min_value,
    output logic                         o_is_empty,
    output logic [CW-1:0]                o_depth,
    output logic [1:0]                   o_status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

    logic signed [DATA_WIDTH-1:0] v_mem [STACK_DEPTH];
    logic signed [DATA_WIDTH-1:0] m_mem [STACK_DEPTH];

    logic [CW-1:0]                r_vcnt;
    logic [CW-1:0]                n_vcnt;
    logic [CW-1:0]                r_mcnt;
    logic [CW-1:0]                n_mcnt;
    logic signed [DATA_WIDTH-1:0] r_top;
    logic signed [DATA_WIDTH-1:0] n_top;
    logic signed [DATA_WIDTH-1:0] r_min;
    logic signed [DATA_WIDTH-1:0] n_min;
    logic signed [DATA_WIDTH-1:0] r_vrd;
    logic signed [DATA_WIDTH-1:0] r_mrd;
    logic [1:0]                   r_status;
    logic [1:0]                   n_status;
    logic                         r_out_valid;

    logic          is_push;
    logic          is_pop;
    logic          push_ok;
    logic          pop_ok;
    logic          push_min;
    logic          pop_min;
    logic          v_we;
    logic          m_we;
    logic [CW-1:0] v_rd_cnt;
    logic [CW-1:0] m_rd_cnt;

    assign is_push  = (i_kind == mts_pkg::KIND_PUSH);
    assign is_pop   = (i_kind == mts_pkg::KIND_POP);
    assign push_ok  = is_push && (r_vcnt != FULL_CNT);
    assign pop_ok   = is_pop && (r_vcnt != '0);
    // min stack never holds more than the value stack, so it cannot be full here
    assign push_min = push_ok && ((r_mcnt == '0) || (i_value <= r_min));
    assign pop_min  = pop_ok && (r_mcnt != '0) && (r_top == r_min);
    assign v_we     = i_cmd.exec && push_ok;
    assign m_we     = i_cmd.exec && push_min;

    // address of the new tops after a pop; wraps harmlessly when the stack empties
    assign v_rd_cnt = r_vcnt - CW'(2);
    assign m_rd_cnt = pop_min ? (r_mcnt - CW'(2)) : (r_mcnt - CW'(1));

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            v_mem[r_vcnt[AW-1:0]] <= i_value;
        end
        r_vrd <= v_mem[v_rd_cnt[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            m_mem[r_mcnt[AW-1:0]] <= i_value;
        end
        r_mrd <= m_mem[m_rd_cnt[AW-1:0]];
    end

    always_comb begin
        n_vcnt   = r_vcnt;
        n_mcnt   = r_mcnt;
        n_top    = r_top;
        n_min    = r_min;
        n_status = r_status;
        if (i_cmd.exec) begin
            n_status = mts_pkg::ST_OK;
            if (is_push) begin
                if (!push_ok) begin
                    n_status = mts_pkg::ST_FULL;
                end else begin
                    n_vcnt = r_vcnt + CW'(1);
                    n_top  = i_value;
                    if (push_min) begin
                        n_mcnt = r_mcnt + CW'(1);
                        n_min  = i_value;
                    end
                end
            end else if (is_pop) begin
                if (!pop_ok) begin
                    n_status = mts_pkg::ST_EMPTY;
                end else begin
                    n_vcnt = r_vcnt - CW'(1);
                    if (pop_min) begin
                        n_mcnt = r_mcnt - CW'(1);
                    end
                end
            end
        end else if (i_cmd.load) begin
            n_top = r_vrd;
            n_min = r_mrd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt <= '0;
            r_mcnt <= '0;
        end else begin
            r_vcnt <= n_vcnt;
            r_mcnt <= n_mcnt;
        end
        r_top    <= n_top;
        r_min    <= n_min;
        r_status <= n_status;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            o_top_value <= (r_vcnt != '0) ? r_top : '0;
            o_min_value <= (r_mcnt != '0) ? r_min : '0;
            o_is_empty  <= (r_vcnt == '0);
            o_depth     <= r_vcnt;
            o_status    <= r_status;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_sts.needs_load = pop_ok;
    assign o_sts.out_free   = !r_out_valid || i_ready;

endmodule
